// ===== design/cartridge_bank_mapper_defines.svh =====
// Assertion helpers used by the mapper controller.
`ifndef CARTRIDGE_BANK_MAPPER_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_DEFINES_SVH

// Checked on every rising clock edge, muted while reset is high.
`define CBM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define CBM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/cbm_pkg.sv =====
`timescale 1ns / 1ps

package cbm_pkg;

   localparam int ADDR_W       = 16;
   localparam int BYTE_W       = 8;
   localparam int PHYS_W       = 23;
   localparam int ROM_BANK_W   = 9;
   localparam int RAM_BANK_W   = 4;
   localparam int ROM_COUNT_W  = 10;
   localparam int RAM_COUNT_W  = 5;
   localparam int ROM_OFFSET_W = 14;   // 16 KiB bank
   localparam int RAM_OFFSET_W = 13;   // 8 KiB bank
   localparam int MAX_ROM_BANKS = 512;
   localparam int MAX_RAM_BANKS = 16;

   // remainder unit runs one dividend bit per step
   localparam int CALC_STEPS = ROM_BANK_W;
   localparam int STEP_W     = 4;

   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_USER_W  = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROM_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAM_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HAS_RAM   = 2'd2;

   typedef enum logic [2:0] {
      TGT_NONE   = 3'd0,
      TGT_ROM_RD = 3'd1,
      TGT_RAM_RD = 3'd2,
      TGT_RAM_WR = 3'd3,
      TGT_REG_WR = 3'd4
   } target_type;

   typedef enum logic [1:0] {
      ST_CALC,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic load_item;   // capture request word
      logic csr_write;   // capture config word
      logic exec;        // decode held item, load response, update bank state
      logic calc_start;  // clear remainder unit
      logic calc_step;   // one remainder step
   } ctrl_cmd_type;

   typedef struct packed {
      logic calc_last;   // final remainder step this cycle
      logic bank_write;  // held item writes a bank register
   } dp_status_type;

endpackage

// ===== design/cbm_bank_mod.sv =====
`timescale 1ns / 1ps

module cbm_bank_mod import cbm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   step,
   input  logic [ROM_BANK_W-1:0]  rom_bank,
   input  logic [ROM_COUNT_W-1:0] rom_div,
   input  logic [RAM_BANK_W-1:0]  ram_bank,
   input  logic [RAM_COUNT_W-1:0] ram_div,
   output logic [ROM_BANK_W-1:0]  rom_rem,
   output logic [RAM_BANK_W-1:0]  ram_rem,
   output logic                   last
);

   logic [STEP_W-1:0]      cnt_ff, cnt_in;
   logic [ROM_BANK_W-1:0]  rom_rem_ff, rom_rem_in;
   logic [RAM_BANK_W-1:0]  ram_rem_ff, ram_rem_in;
   logic [STEP_W-1:0]      bit_idx;
   logic [ROM_BANK_W-1:0]  ram_dvd;
   logic [ROM_COUNT_W-1:0] rom_trial;
   logic [RAM_COUNT_W-1:0] ram_trial;

   // restoring remainder, MSB first; both banks share the step count
   always_comb begin
      bit_idx   = STEP_W'(CALC_STEPS - 1) - cnt_ff;
      ram_dvd   = ROM_BANK_W'(ram_bank);
      rom_trial = {rom_rem_ff, rom_bank[bit_idx]};
      ram_trial = {ram_rem_ff, ram_dvd[bit_idx]};
      last      = step && (cnt_ff == STEP_W'(CALC_STEPS - 1));
      cnt_in     = cnt_ff;
      rom_rem_in = rom_rem_ff;
      ram_rem_in = ram_rem_ff;
      if (start) begin
         cnt_in     = '0;
         rom_rem_in = '0;
         ram_rem_in = '0;
      end else if (step) begin
         cnt_in     = cnt_ff + STEP_W'(1);
         rom_rem_in = (rom_trial >= rom_div) ? ROM_BANK_W'(rom_trial - rom_div)
                                             : ROM_BANK_W'(rom_trial);
         ram_rem_in = (ram_trial >= ram_div) ? RAM_BANK_W'(ram_trial - ram_div)
                                             : RAM_BANK_W'(ram_trial);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         rom_rem_ff <= '0;
         ram_rem_ff <= '0;
      end else begin
         cnt_ff     <= cnt_in;
         rom_rem_ff <= rom_rem_in;
         ram_rem_ff <= ram_rem_in;
      end
   end

   assign rom_rem = rom_rem_ff;
   assign ram_rem = ram_rem_ff;

endmodule

// ===== design/cbm_dpath.sv =====
`timescale 1ns / 1ps

module cbm_dpath import cbm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tuser,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic [RSP_USER_W-1:0]  rsp_tuser
);

   // config
   logic [ROM_COUNT_W-1:0] rom_count_ff;
   logic [RAM_COUNT_W-1:0] ram_count_ff;
   logic                   has_ram_ff;
   // mapper state
   logic [ROM_BANK_W-1:0]  rom_bank_ff, rom_bank_in;
   logic [RAM_BANK_W-1:0]  ram_bank_ff, ram_bank_in;
   logic                   ram_en_ff, ram_en_in;
   logic                   dirty_ff, dirty_in;
   // held item
   logic                   is_write_ff;
   logic [ADDR_W-1:0]      addr_ff;
   logic [BYTE_W-1:0]      wdata_ff;
   // response
   target_type             target_ff, target_in;
   logic [PHYS_W-1:0]      phys_ff, phys_in;
   logic [BYTE_W-1:0]      dout_ff, dout_in;
   logic                   rsp_dirty_ff;

   logic [ROM_COUNT_W-1:0] rom_div;
   logic [RAM_COUNT_W-1:0] ram_div;
   logic [ROM_BANK_W-1:0]  rom_rem;
   logic [RAM_BANK_W-1:0]  ram_rem;
   logic                   ram_ok;
   logic                   in_ram_win;

   // zero ROM count acts as one bank; both counts saturate
   always_comb begin
      if (rom_count_ff == '0)
         rom_div = ROM_COUNT_W'(1);
      else if (rom_count_ff > ROM_COUNT_W'(MAX_ROM_BANKS))
         rom_div = ROM_COUNT_W'(MAX_ROM_BANKS);
      else
         rom_div = rom_count_ff;
      if (ram_count_ff == '0)
         ram_div = RAM_COUNT_W'(1);   // RAM is off then, value unused
      else if (ram_count_ff > RAM_COUNT_W'(MAX_RAM_BANKS))
         ram_div = RAM_COUNT_W'(MAX_RAM_BANKS);
      else
         ram_div = ram_count_ff;
   end

   cbm_bank_mod u_bank_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.calc_start),
      .step     (cmd.calc_step),
      .rom_bank (rom_bank_ff),
      .rom_div  (rom_div),
      .ram_bank (ram_bank_ff),
      .ram_div  (ram_div),
      .rom_rem  (rom_rem),
      .ram_rem  (ram_rem),
      .last     (status.calc_last)
   );

   assign status.bank_write = is_write_ff && (addr_ff >= 16'h2000) && (addr_ff <= 16'h5FFF);

   always_comb begin
      ram_ok      = has_ram_ff && (ram_count_ff != '0) && ram_en_ff;
      in_ram_win  = (addr_ff >= 16'hA000) && (addr_ff <= 16'hBFFF);
      target_in   = TGT_NONE;
      phys_in     = '0;
      dout_in     = '0;
      rom_bank_in = rom_bank_ff;
      ram_bank_in = ram_bank_ff;
      ram_en_in   = ram_en_ff;
      dirty_in    = dirty_ff;
      if (is_write_ff) begin
         if (addr_ff <= 16'h1FFF) begin
            ram_en_in = (wdata_ff[3:0] == 4'hA);
            target_in = TGT_REG_WR;
         end else if (addr_ff <= 16'h2FFF) begin
            rom_bank_in = {rom_bank_ff[ROM_BANK_W-1], wdata_ff};
            target_in   = TGT_REG_WR;
         end else if (addr_ff <= 16'h3FFF) begin
            rom_bank_in = {wdata_ff[0], rom_bank_ff[ROM_BANK_W-2:0]};
            target_in   = TGT_REG_WR;
         end else if (addr_ff <= 16'h5FFF) begin
            ram_bank_in = wdata_ff[RAM_BANK_W-1:0];
            target_in   = TGT_REG_WR;
         end
      end else if (addr_ff <= 16'h3FFF) begin
         target_in = TGT_ROM_RD;
         phys_in   = PHYS_W'(addr_ff);
      end else if (addr_ff <= 16'h7FFF) begin
         target_in = TGT_ROM_RD;
         phys_in   = {rom_rem, addr_ff[ROM_OFFSET_W-1:0]};
      end
      if (in_ram_win && ram_ok) begin
         phys_in = PHYS_W'({ram_rem, addr_ff[RAM_OFFSET_W-1:0]});
         if (is_write_ff) begin
            target_in = TGT_RAM_WR;
            dout_in   = wdata_ff;
            dirty_in  = 1'b1;
         end else begin
            target_in = TGT_RAM_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_count_ff <= ROM_COUNT_W'(2);
         ram_count_ff <= '0;
         has_ram_ff   <= 1'b0;
         rom_bank_ff  <= ROM_BANK_W'(1);
         ram_bank_ff  <= '0;
         ram_en_ff    <= 1'b0;
         dirty_ff     <= 1'b0;
      end else begin
         if (cmd.csr_write) begin
            unique case (csr_index)
               CSR_ROM_COUNT: rom_count_ff <= csr_data;
               CSR_RAM_COUNT: ram_count_ff <= csr_data[RAM_COUNT_W-1:0];
               CSR_HAS_RAM:   has_ram_ff   <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.exec) begin
            rom_bank_ff <= rom_bank_in;
            ram_bank_ff <= ram_bank_in;
            ram_en_ff   <= ram_en_in;
            dirty_ff    <= dirty_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         is_write_ff <= req_tuser;
         addr_ff     <= req_tdata[ADDR_W-1:0];
         wdata_ff    <= req_tdata[ADDR_W+BYTE_W-1:ADDR_W];
      end
      if (cmd.exec) begin
         target_ff    <= target_in;
         phys_ff      <= phys_in;
         dout_ff      <= dout_in;
         rsp_dirty_ff <= dirty_in;
      end
   end

   assign rsp_tdata = {rsp_dirty_ff, dout_ff, phys_ff};
   assign rsp_tuser = target_ff;

endmodule

// ===== design/cbm_ctrl.sv =====
`timescale 1ns / 1ps

`include "cartridge_bank_mapper_defines.svh"

module cbm_ctrl import cbm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic          csr_valid,
   output logic          csr_ready,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;
   logic      req_accept;
   logic      csr_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CALC;   // reset values need their remainders too
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      csr_ready    = 1'b0;
      req_tready   = 1'b0;
      rsp_free     = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_CALC: begin
            cmd.calc_step = 1'b1;
            if (status.calc_last)
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            // config has priority over a request
            csr_ready  = 1'b1;
            req_tready = !csr_valid;
            if (csr_valid) begin
               cmd.csr_write  = 1'b1;
               cmd.calc_start = 1'b1;
               state_in       = ST_CALC;
            end else if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (rsp_free) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.bank_write) begin
                  cmd.calc_start = 1'b1;
                  state_in       = ST_CALC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_CALC;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign csr_accept = csr_valid && csr_ready;

   `CBM_ASSERT(a_no_dual_accept, !(req_accept && csr_accept), "config and request taken together")
   `CBM_ASSERT(a_exec_delivers, (state_ff == ST_EXEC && rsp_free) |=> rsp_valid_ff, "response not loaded")
   `CBM_ASSERT(a_calc_ends, (state_ff == ST_CALC && status.calc_last) |=> (state_ff == ST_IDLE), "remainder pass did not finish")
   `CBM_ASSERT_ALWAYS(a_reset_quiet, reset |=> (!rsp_tvalid && !req_tready), "activity right after reset")

endmodule

// ===== design/cartridge_bank_mapper.sv =====
`timescale 1ns / 1ps

// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+---------------------------------------
// req       | in        | req_tvalid/req_tready | tuser: cmd; tdata: address, write_data
// rsp       | out       | rsp_tvalid/rsp_tready | tuser: target; tdata: phys_addr,
//           |           |                       |   data_out, ram_dirty
// csr       | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// Reads, RAM writes, RAM enable writes and unmapped words pass through the idle and
// exec states. A ROM or RAM bank register write then runs a remainder pass: the bank
// modulo is worked out one dividend bit a cycle by a shared remainder unit; a config
// write likewise runs a pass of that unit before the next request.
// After reset the unit runs its pass before the first request is taken.
// A stalled response holds in its register; one further request is taken and
// waits until the response slot frees up.

module cartridge_bank_mapper import cbm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [15:0] address, [23:16] write_data
   input  logic                   req_tuser,   // [0] cmd (1 write)
   // response
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [22:0] phys_addr, [30:23] data_out,
                                               // [31] ram_dirty
   output logic [RSP_USER_W-1:0]  rsp_tuser,   // [2:0] target
   // config
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,   // 0 rom count, 1 ram count, 2 has_ram
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: accept, execute, bank modulo pass
   cbm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .cmd        (cmd),
      .status     (status)
   );

   // bank registers, address decode, response word
   cbm_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ===== verif/tb_cartridge_bank_mapper.sv =====
`timescale 1ns / 1ps

module tb_cartridge_bank_mapper;
   import cbm_pkg::*;

   localparam int ROM_BANK_BYTES = 1 << ROM_OFFSET_W;
   localparam int RAM_BANK_BYTES = 1 << RAM_OFFSET_W;
   localparam int DRAIN_CYCLES   = 2 * CALC_STEPS + 6;

   // one expected response word
   typedef struct packed {
      target_type            target;
      logic [PHYS_W-1:0]     phys;
      logic [BYTE_W-1:0]     wdata;
      logic                  dirty;
   } bus_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ROM_COUNT;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // mirrored mapper state and config
   logic [ROM_BANK_W-1:0]  rom_bank;
   logic [RAM_BANK_W-1:0]  ram_bank;
   logic                   ram_enabled;
   logic                   dirty_seen;
   logic [ROM_COUNT_W-1:0] rom_count;
   logic [RAM_COUNT_W-1:0] ram_count;
   logic                   ram_fitted;

   bus_result_type pending_maps[$];
   int mismatch_count  = 0;
   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int rsp_hold_cycles = 0;

   cartridge_bank_mapper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb_cartridge_bank_mapper: FAIL");
      $finish;
   end

   // Decode one CPU access against the mirrored state and update it.
   function automatic bus_result_type map_access(input logic wr,
                                                 input logic [ADDR_W-1:0] addr,
                                                 input logic [BYTE_W-1:0] data);
      bus_result_type r;
      int rom_lim;
      int ram_lim;
      int bank;
      r = '{TGT_NONE, '0, '0, 1'b0};
      if (wr) begin
         if (addr <= 16'h1FFF) begin
            ram_enabled = (data[3:0] == 4'hA);
            r.target = TGT_REG_WR;
         end else if (addr <= 16'h2FFF) begin
            rom_bank[7:0] = data;
            r.target = TGT_REG_WR;
         end else if (addr <= 16'h3FFF) begin
            rom_bank[8] = data[0];
            r.target = TGT_REG_WR;
         end else if (addr <= 16'h5FFF) begin
            ram_bank = data[3:0];
            r.target = TGT_REG_WR;
         end
      end else if (addr <= 16'h3FFF) begin
         r.target = TGT_ROM_RD;
         r.phys = PHYS_W'(addr);
      end else if (addr <= 16'h7FFF) begin
         // zero count acts as one bank, oversized count clamps
         rom_lim = (rom_count == 0) ? 1 :
                   (int'(rom_count) > MAX_ROM_BANKS) ? MAX_ROM_BANKS : int'(rom_count);
         bank = int'(rom_bank) % rom_lim;
         r.target = TGT_ROM_RD;
         r.phys = PHYS_W'(bank * ROM_BANK_BYTES + int'(addr) - 'h4000);
      end
      if (addr >= 16'hA000 && addr <= 16'hBFFF) begin
         ram_lim = (int'(ram_count) > MAX_RAM_BANKS) ? MAX_RAM_BANKS : int'(ram_count);
         if (ram_fitted && ram_lim != 0 && ram_enabled) begin
            bank = int'(ram_bank) % ram_lim;
            r.phys = PHYS_W'(bank * RAM_BANK_BYTES + int'(addr) - 'hA000);
            if (wr) begin
               r.target = TGT_RAM_WR;
               r.wdata = data;
               dirty_seen = 1'b1;
            end else begin
               r.target = TGT_RAM_RD;
            end
         end
      end
      r.dirty = dirty_seen;
      return r;
   endfunction

   // Response side: check accepted words, then pick next ready.
   initial begin : rsp_monitor
      bus_result_type got;
      bus_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = '{target_type'(rsp_tuser), rsp_tdata[PHYS_W-1:0],
                    rsp_tdata[PHYS_W+BYTE_W-1:PHYS_W], rsp_tdata[PHYS_W+BYTE_W]};
            if (pending_maps.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected response word: target %0d phys %h", rsp_tuser,
                           got.phys);
               mismatch_count++;
            end else begin
               want = pending_maps.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10)
                     $display({"response mismatch: target exp %0d got %0d, phys exp %h got %h,",
                               " data exp %h got %h, dirty exp %0b got %0b"},
                              want.target, rsp_tuser, want.phys, got.phys,
                              want.wdata, got.wdata, want.dirty, got.dirty);
                  mismatch_count++;
               end
            end
         end
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Drops valid, waits out every pending response plus the bank modulo pass.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_maps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [BYTE_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= wr;
      req_tdata  <= {data, addr};
      do @(posedge clock); while (!req_tready);
      pending_maps.push_back(map_access(wr, addr, data));
   endtask

   // Writes all three registers in turn, only with the block idle.
   task automatic set_config(input logic [ROM_COUNT_W-1:0] rom_n,
                             input logic [RAM_COUNT_W-1:0] ram_n, input logic ram_on);
      logic [CSR_INDEX_W-1:0] idx [3];
      logic [CSR_DATA_W-1:0]  vals [3];
      idx[0]  = CSR_ROM_COUNT;
      idx[1]  = CSR_RAM_COUNT;
      idx[2]  = CSR_HAS_RAM;
      vals[0] = CSR_DATA_W'(rom_n);
      vals[1] = CSR_DATA_W'(ram_n);
      vals[2] = CSR_DATA_W'(ram_on);
      wait_drained();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      rom_count  = rom_n;
      ram_count  = ram_n;
      ram_fitted = ram_on;
   endtask

   // Mostly well-formed traffic: enables, bank selects, ROM and RAM windows.
   task automatic send_random_access();
      logic              wr;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
      int                pick;
      pick = $urandom_range(99);
      wr   = 1'($urandom_range(1));
      addr = ADDR_W'($urandom_range(16'hFFFF));
      data = BYTE_W'($urandom_range(255));
      if (pick < 15) begin
         wr = 1'b1;
         addr = ADDR_W'($urandom_range(16'h1FFF));
         if ($urandom_range(3) != 0) data[3:0] = 4'hA;
      end else if (pick < 25) begin
         wr = 1'b1;
         addr = ADDR_W'($urandom_range(16'h2FFF, 16'h2000));
      end else if (pick < 30) begin
         wr = 1'b1;
         addr = ADDR_W'($urandom_range(16'h3FFF, 16'h3000));
      end else if (pick < 38) begin
         wr = 1'b1;
         addr = ADDR_W'($urandom_range(16'h5FFF, 16'h4000));
      end else if (pick < 58) begin
         wr = 1'b0;
         addr = ADDR_W'($urandom_range(16'h7FFF));
      end else if (pick < 83) begin
         addr = ADDR_W'($urandom_range(16'hBFFF, 16'hA000));
      end
      // remainder: unconstrained noise over the whole map
      send_access(wr, addr, data);
   endtask

   function automatic logic [ROM_COUNT_W-1:0] pick_rom_count();
      case ($urandom_range(6))
         0: return 10'd1;
         1: return 10'd2;
         2: return 10'd512;
         3: return 10'd0;
         4: return 10'd1023;
         5: return 10'($urandom_range(1023, 513));
         default: return 10'($urandom_range(512, 3));
      endcase
   endfunction

   function automatic logic [RAM_COUNT_W-1:0] pick_ram_count();
      case ($urandom_range(5))
         0: return 5'd0;
         1: return 5'd1;
         2: return 5'd16;
         3: return 5'($urandom_range(31, 17));
         default: return 5'($urandom_range(15, 2));
      endcase
   endfunction

   // Reset config: 2 ROM banks, no RAM. Covers unmapped ranges too.
   task automatic test_reset_map();
      send_access(1'b0, 16'h0000, 8'h00);
      send_access(1'b0, 16'h3FFF, 8'hFF);
      send_access(1'b0, 16'h4000, 8'h00);
      send_access(1'b0, 16'h7FFF, 8'h00);
      send_access(1'b1, 16'h6000, 8'h0A);
      send_access(1'b1, 16'h8000, 8'h55);
      send_access(1'b1, 16'hFFFF, 8'hAA);
      send_access(1'b0, 16'h9FFF, 8'h00);
      send_access(1'b0, 16'hC000, 8'h00);
      send_access(1'b0, 16'hA000, 8'h00);
      send_access(1'b1, 16'hBFFF, 8'h12);
   endtask

   // Full-size cartridge: 9-bit bank select, bank 0 in the upper window,
   // RAM enable and disable, dirty flag.
   task automatic test_bank_select();
      set_config(10'd512, 5'd16, 1'b1);
      send_access(1'b1, 16'h1FFF, 8'h5A);
      send_access(1'b1, 16'h2000, 8'hFF);
      send_access(1'b1, 16'h3FFF, 8'h01);
      send_access(1'b0, 16'h4000, 8'h00);
      send_access(1'b0, 16'h7FFF, 8'h00);
      send_access(1'b1, 16'h2FFF, 8'h00);
      send_access(1'b1, 16'h3000, 8'hFE);
      send_access(1'b0, 16'h5555, 8'h00);
      send_access(1'b1, 16'h4000, 8'hF7);
      send_access(1'b1, 16'hA000, 8'h00);
      send_access(1'b0, 16'hBFFF, 8'h00);
      send_access(1'b1, 16'h5FFF, 8'hFF);
      send_access(1'b1, 16'hBFFF, 8'hFF);
      send_access(1'b1, 16'h0000, 8'h0B);
      send_access(1'b0, 16'hA123, 8'h00);
      send_access(1'b1, 16'h1000, 8'hFA);
   endtask

   // Zero and oversized bank counts, RAM missing or zero-sized.
   task automatic test_count_limits();
      set_config(10'd0, 5'd31, 1'b1);
      send_access(1'b0, 16'h4000, 8'h00);
      send_access(1'b1, 16'h2000, 8'h03);
      send_access(1'b0, 16'h7000, 8'h00);
      send_access(1'b0, 16'hA000, 8'h00);
      set_config(10'd1023, 5'd17, 1'b1);
      send_access(1'b1, 16'h2000, 8'hFF);
      send_access(1'b1, 16'h3000, 8'h01);
      send_access(1'b0, 16'h7FFF, 8'h00);
      send_access(1'b0, 16'hBFFF, 8'h00);
      set_config(10'd512, 5'd16, 1'b0);
      send_access(1'b0, 16'hA000, 8'h00);
      set_config(10'd3, 5'd0, 1'b1);
      send_access(1'b0, 16'h6000, 8'h00);
      send_access(1'b0, 16'hA000, 8'h00);
      set_config(10'd1, 5'd1, 1'b1);
      send_access(1'b1, 16'hB000, 8'hC3);
   endtask

   // Long response hold-off fills the block; then drained bursts.
   task automatic test_output_stall();
      set_config(10'd64, 5'd4, 1'b1);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_cycles = 200;
      repeat (24) send_random_access();
      wait_drained();
      repeat (8) send_random_access();
      wait_drained();
      repeat (8) send_random_access();
   endtask

   // Random phases over the four idle mixes, fresh config each phase.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 8; phase++) begin
         set_config(pick_rom_count(), pick_ram_count(), ($urandom_range(3) != 0));
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 53; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 53; end
            default: begin send_idle_pct = 12; rsp_stall_pct = 12; end
         endcase
         repeat (110) send_random_access();
      end
   endtask

   initial begin
      rom_bank    = 9'd1;
      ram_bank    = '0;
      ram_enabled = 1'b0;
      dirty_seen  = 1'b0;
      rom_count   = 10'd2;
      ram_count   = '0;
      ram_fitted  = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_map();
      test_bank_select();
      test_count_limits();
      test_output_stall();
      test_random_traffic();

      wait_drained();
      mismatch_count += pending_maps.size();
      if (mismatch_count == 0) begin
         $display("tb_cartridge_bank_mapper: PASS");
      end else begin
         $display("tb_cartridge_bank_mapper: FAIL");
      end
      $finish;
   end

endmodule
